// File: rtl/oal_pkg.sv
// ----------------------------------------------------------------------------
// oal_pkg: shared definitions for the ordered array list engine
// Sizes, action and status codes, cell control and tree node types.
// ----------------------------------------------------------------------------
`default_nettype none

package oal_pkg;

    localparam int CAPACITY   = 128;
    localparam int DATA_WIDTH = 32;

    // entry index, entry count and position compare widths
    localparam int IDX_W   = $clog2(CAPACITY);
    localparam int CNT_W   = $clog2(CAPACITY + 1);
    localparam int POS_W   = 8;
    localparam int CMP_W   = (CNT_W > POS_W) ? CNT_W : POS_W;
    localparam int LEAVES  = 1 << IDX_W;
    localparam int WAIT_W  = $clog2(IDX_W + 1);

    // actions
    localparam logic [1:0] ACT_INSERT = 2'd0;
    localparam logic [1:0] ACT_DELETE = 2'd1;
    localparam logic [1:0] ACT_READ   = 2'd2;
    localparam logic [1:0] ACT_SEARCH = 2'd3;

    // result status
    localparam logic [1:0] STAT_OK       = 2'd0;
    localparam logic [1:0] STAT_FULL     = 2'd1;
    localparam logic [1:0] STAT_RANGE    = 2'd2;
    localparam logic [1:0] STAT_NOTFOUND = 2'd3;

    // broadcast to every cell
    typedef struct packed {
        logic                  ins;
        logic                  del;
        logic                  srch;
        logic [CMP_W-1:0]      pos;
        logic [CNT_W-1:0]      count;
        logic [DATA_WIDTH-1:0] value;
    } cell_ctrl_t;

    // one node of the first-hit tree
    typedef struct packed {
        logic                  hit;
        logic [IDX_W-1:0]      idx;
        logic [DATA_WIDTH-1:0] data;
    } tree_node_t;

    // stored word to 32-bit result field, sign-extended
    function automatic logic [31:0] word_to_field(input logic [DATA_WIDTH-1:0] w);
        logic signed [63:0] wide;
        begin
            wide = 64'($signed(w));
            return wide[31:0];
        end
    endfunction

endpackage

`default_nettype wire

// File: rtl/ordered_array_list_engine.sv
// ----------------------------------------------------------------------------
// ordered_array_list_engine: fixed-capacity ordered list of words
// Insert, delete, read by position and search by value over a row of cells.
// ----------------------------------------------------------------------------
// Insert/delete/rejected items: ST_EXEC checks and applies the captured item,
//   then ST_DONE loads the result into the output register.
// Read/search: ST_WAIT waits out the leaf register plus log2(CAPACITY) tree
//   levels, then ST_DONE loads the result into the output register.
// One item in flight; input stalls until its result sits in the output reg.
// Reset empties the list (count zero); entry words are not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module ordered_array_list_engine (
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input channel
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic [1:0]         action,
    input  wire logic [7:0]         position,
    input  wire logic signed [31:0] value,
    // result channel
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              status,
    output logic [6:0]              found_position,
    output logic signed [31:0]      read_value,
    output logic [7:0]              list_length,
    output logic                    is_empty,
    output logic                    is_full
);

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;   // waiting for a transfer
    localparam logic [1:0] ST_EXEC = 2'd1;   // check, shift cells, load tree leaves
    localparam logic [1:0] ST_WAIT = 2'd2;   // tree settling
    localparam logic [1:0] ST_DONE = 2'd3;   // result ready for output register

    logic [1:0] state_reg, state_next;

    // captured item
    logic [1:0]                      op_action_reg, op_action_next;
    logic [oal_pkg::CMP_W-1:0]       op_pos_reg, op_pos_next;
    logic [oal_pkg::DATA_WIDTH-1:0]  op_value_reg, op_value_next;

    // list length
    logic [oal_pkg::CNT_W-1:0]       count_reg, count_next;

    logic [oal_pkg::WAIT_W-1:0]      wait_cnt_reg, wait_cnt_next;

    // pending result
    logic [1:0]                      res_status_reg, res_status_next;
    logic [oal_pkg::IDX_W-1:0]       res_found_reg, res_found_next;
    logic [31:0]                     res_data_reg, res_data_next;

    // output register
    logic                            out_valid_reg, out_valid_next;
    logic [1:0]                      status_reg;
    logic [6:0]                      found_reg;
    logic [31:0]                     read_reg;
    logic [7:0]                      length_reg;
    logic                            empty_reg;
    logic                            full_reg;
    logic                            out_load;

    // checks against the current length
    logic list_full;
    logic pos_gt_cnt;
    logic pos_ge_cnt;
    logic ins_ok;
    logic del_ok;

    oal_pkg::cell_ctrl_t  ctrl;
    oal_pkg::tree_node_t  root;

    logic [oal_pkg::DATA_WIDTH-1:0] entries [oal_pkg::CAPACITY];
    logic [oal_pkg::CAPACITY-1:0]   hits;

    assign list_full  = (count_reg == oal_pkg::CNT_W'(oal_pkg::CAPACITY));
    assign pos_gt_cnt = (op_pos_reg >  oal_pkg::CMP_W'(count_reg));
    assign pos_ge_cnt = (op_pos_reg >= oal_pkg::CMP_W'(count_reg));
    assign ins_ok     = (op_action_reg == oal_pkg::ACT_INSERT) && !list_full && !pos_gt_cnt;
    assign del_ok     = (op_action_reg == oal_pkg::ACT_DELETE) && !pos_ge_cnt;

    // cell broadcast: shifts only fire during the execute cycle
    assign ctrl.ins   = (state_reg == ST_EXEC) && ins_ok;
    assign ctrl.del   = (state_reg == ST_EXEC) && del_ok;
    assign ctrl.srch  = (op_action_reg == oal_pkg::ACT_SEARCH);
    assign ctrl.pos   = op_pos_reg;
    assign ctrl.count = count_reg;
    assign ctrl.value = op_value_reg;

    // row of cells, each fed by its neighbors; ends see zero
    for (genvar i = 0; i < oal_pkg::CAPACITY; i++)
    begin : g_cell
        logic [oal_pkg::DATA_WIDTH-1:0] left_w;
        logic [oal_pkg::DATA_WIDTH-1:0] right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_inner_l
            assign left_w = entries[i-1];
        end

        if (i == oal_pkg::CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_inner_r
            assign right_w = entries[i+1];
        end

        oal_cell u_cell (
            .clk         (clk),
            .ctrl        (ctrl),
            .cell_idx    (oal_pkg::IDX_W'(i)),
            .left_entry  (left_w),
            .right_entry (right_w),
            .entry       (entries[i]),
            .hit         (hits[i])
        );
    end

    // lowest hitting cell, log2(CAPACITY) register levels after the leaves
    oal_tree u_tree (
        .clk       (clk),
        .leaf_hit  (hits),
        .leaf_data (entries),
        .root      (root)
    );

    assign out_load = !out_valid_reg || !out_stall;

    always_comb
    begin
        state_next      = state_reg;
        op_action_next  = op_action_reg;
        op_pos_next     = op_pos_reg;
        op_value_next   = op_value_reg;
        count_next      = count_reg;
        wait_cnt_next   = wait_cnt_reg;
        res_status_next = res_status_reg;
        res_found_next  = res_found_reg;
        res_data_next   = res_data_reg;
        out_valid_next  = out_valid_reg && out_stall;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    op_action_next = action;
                    op_pos_next    = oal_pkg::CMP_W'(position);
                    op_value_next  = oal_pkg::DATA_WIDTH'($unsigned(value));
                    state_next     = ST_EXEC;
                end
            end

            ST_EXEC:
            begin
                res_status_next = oal_pkg::STAT_OK;
                res_found_next  = '0;
                res_data_next   = '0;
                state_next      = ST_DONE;
                unique case (op_action_reg)
                    oal_pkg::ACT_INSERT:
                    begin
                        if (list_full)
                            res_status_next = oal_pkg::STAT_FULL;
                        else if (pos_gt_cnt)
                            res_status_next = oal_pkg::STAT_RANGE;
                        else
                            count_next = count_reg + 1'b1;
                    end
                    oal_pkg::ACT_DELETE:
                    begin
                        if (pos_ge_cnt)
                            res_status_next = oal_pkg::STAT_RANGE;
                        else
                            count_next = count_reg - 1'b1;
                    end
                    oal_pkg::ACT_READ:
                    begin
                        if (pos_ge_cnt)
                            res_status_next = oal_pkg::STAT_RANGE;
                        else
                        begin
                            wait_cnt_next = oal_pkg::WAIT_W'(oal_pkg::IDX_W);
                            state_next    = ST_WAIT;
                        end
                    end
                    oal_pkg::ACT_SEARCH:
                    begin
                        wait_cnt_next = oal_pkg::WAIT_W'(oal_pkg::IDX_W);
                        state_next    = ST_WAIT;
                    end
                    default:
                    begin
                        state_next = ST_DONE;
                    end
                endcase
            end

            ST_WAIT:
            begin
                if (wait_cnt_reg == '0)
                begin
                    state_next = ST_DONE;
                    if (op_action_reg == oal_pkg::ACT_READ)
                    begin
                        res_status_next = oal_pkg::STAT_OK;
                        res_data_next   = oal_pkg::word_to_field(root.data);
                    end
                    else if (root.hit)
                    begin
                        res_status_next = oal_pkg::STAT_OK;
                        res_found_next  = root.idx;
                    end
                    else
                    begin
                        res_status_next = oal_pkg::STAT_NOTFOUND;
                    end
                end
                else
                begin
                    wait_cnt_next = wait_cnt_reg - 1'b1;
                end
            end

            ST_DONE:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            wait_cnt_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            wait_cnt_reg  <= wait_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        op_action_reg  <= op_action_next;
        op_pos_reg     <= op_pos_next;
        op_value_reg   <= op_value_next;
        res_status_reg <= res_status_next;
        res_found_reg  <= res_found_next;
        res_data_reg   <= res_data_next;
        if ((state_reg == ST_DONE) && out_load)
        begin
            // count_reg already holds the length after the action
            status_reg <= res_status_reg;
            found_reg  <= 7'(res_found_reg);
            read_reg   <= res_data_reg;
            length_reg <= 8'(count_reg);
            empty_reg  <= (count_reg == '0);
            full_reg   <= (count_reg == oal_pkg::CNT_W'(oal_pkg::CAPACITY));
        end
    end

    assign in_stall       = (state_reg != ST_IDLE);
    assign out_valid      = out_valid_reg;
    assign status         = status_reg;
    assign found_position = found_reg;
    assign read_value     = read_reg;
    assign list_length    = length_reg;
    assign is_empty       = empty_reg;
    assign is_full        = full_reg;

endmodule

`default_nettype wire

// File: rtl/oal_cell.sv
// ----------------------------------------------------------------------------
// oal_cell: one list entry
// Holds one word, shifts from a neighbor on insert or delete, flags a hit.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_cell (
    input  wire logic                          clk,
    input  wire oal_pkg::cell_ctrl_t           ctrl,
    input  wire logic [oal_pkg::IDX_W-1:0]     cell_idx,
    input  wire logic [oal_pkg::DATA_WIDTH-1:0] left_entry,
    input  wire logic [oal_pkg::DATA_WIDTH-1:0] right_entry,
    output logic      [oal_pkg::DATA_WIDTH-1:0] entry,
    output logic                               hit
);

    logic [oal_pkg::DATA_WIDTH-1:0] entry_reg;
    logic [oal_pkg::DATA_WIDTH-1:0] entry_next;
    logic [oal_pkg::CMP_W-1:0]      my_idx;

    assign my_idx = oal_pkg::CMP_W'(cell_idx);

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.ins)
        begin
            if (my_idx == ctrl.pos)
                entry_next = ctrl.value;
            else if (my_idx > ctrl.pos)
                entry_next = left_entry;
        end
        else if (ctrl.del)
        begin
            if (my_idx >= ctrl.pos)
                entry_next = right_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    // search: live entry equal to value; read: position match
    assign hit = ctrl.srch
               ? ((my_idx < oal_pkg::CMP_W'(ctrl.count)) && (entry_reg == ctrl.value))
               : (my_idx == ctrl.pos);

    assign entry = entry_reg;

endmodule

`default_nettype wire

// File: rtl/oal_tree.sv
// ----------------------------------------------------------------------------
// oal_tree: registered first-hit tree
// Binary tree, one register level per tree level; lower index wins.
// ----------------------------------------------------------------------------
`default_nettype none

module oal_tree (
    input  wire logic                          clk,
    input  wire logic [oal_pkg::CAPACITY-1:0]  leaf_hit,
    input  wire logic [oal_pkg::DATA_WIDTH-1:0] leaf_data [oal_pkg::CAPACITY],
    output oal_pkg::tree_node_t                root
);

    // heap order: node n has children 2n and 2n+1, leaves from LEAVES up
    oal_pkg::tree_node_t node_reg [1:2*oal_pkg::LEAVES-1];

    always_ff @(posedge clk)
    begin
        for (int n = oal_pkg::LEAVES; n < 2 * oal_pkg::LEAVES; n++)
        begin
            node_reg[n].idx <= oal_pkg::IDX_W'(n - oal_pkg::LEAVES);
            if (n - oal_pkg::LEAVES < oal_pkg::CAPACITY)
            begin
                node_reg[n].hit  <= leaf_hit[n - oal_pkg::LEAVES];
                node_reg[n].data <= leaf_data[n - oal_pkg::LEAVES];
            end
            else
            begin
                node_reg[n].hit  <= 1'b0;
                node_reg[n].data <= '0;
            end
        end
        for (int n = 1; n < oal_pkg::LEAVES; n++)
        begin
            node_reg[n] <= node_reg[2*n].hit ? node_reg[2*n] : node_reg[2*n+1];
        end
    end

    assign root = node_reg[1];

endmodule

`default_nettype wire

// File: sim/list_checker.sv
// ----------------------------------------------------------------------------
// list_checker: result predictor and scoreboard for the ordered list engine
// Follows every input transfer with its own copy of the list, queues the
// result it expects and compares each result transfer field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module list_checker
    import oal_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input channel, observed
    input  wire logic               in_valid,
    input  wire logic               in_stall,
    input  wire logic [1:0]         action,
    input  wire logic [7:0]         position,
    input  wire logic signed [31:0] value,
    // result channel, observed
    input  wire logic               out_valid,
    input  wire logic               out_stall,
    input  wire logic [1:0]         status,
    input  wire logic [6:0]         found_position,
    input  wire logic signed [31:0] read_value,
    input  wire logic [7:0]         list_length,
    input  wire logic               is_empty,
    input  wire logic               is_full,
    // to the top
    output int                      mismatch_count,
    output int                      outstanding
);

    typedef struct packed {
        logic [1:0]  status;
        logic [6:0]  found_position;
        logic [31:0] read_value;
        logic [7:0]  list_length;
        logic        is_empty;
        logic        is_full;
    } list_result_t;

    logic [DATA_WIDTH-1:0] entries [CAPACITY];
    int                    fill;
    list_result_t          awaited_results[$];
    list_result_t          oldest;
    int                    fails = 0;

    // apply one action to the shadow list, return the result it should give
    function automatic list_result_t apply_action(input logic [1:0] act,
                                                  input logic [7:0] pos,
                                                  input logic [31:0] val);
        list_result_t          res;
        logic [DATA_WIDTH-1:0] word;
        int                    p;
        int                    i;
        bit                    hit;
        begin
            res    = '0;
            word   = val[DATA_WIDTH-1:0];
            p      = int'(pos);
            hit    = 1'b0;
            res.status = STAT_OK;
            case (act)
                ACT_INSERT:
                begin
                    // fullness wins over a bad position
                    if (fill >= CAPACITY)
                        res.status = STAT_FULL;
                    else if (p > fill)
                        res.status = STAT_RANGE;
                    else
                    begin
                        for (i = fill; i > p; i--)
                            entries[i] = entries[i-1];
                        entries[p] = word;
                        fill++;
                    end
                end
                ACT_DELETE:
                begin
                    if (p >= fill)
                        res.status = STAT_RANGE;
                    else
                    begin
                        for (i = p; i + 1 < fill; i++)
                            entries[i] = entries[i+1];
                        fill--;
                    end
                end
                ACT_READ:
                begin
                    if (p >= fill)
                        res.status = STAT_RANGE;
                    else
                        res.read_value = 32'($signed(entries[p]));
                end
                default:
                begin
                    // search: lowest matching position wins
                    res.status = STAT_NOTFOUND;
                    for (i = 0; i < fill; i++)
                    begin
                        if (!hit && entries[i] == word)
                        begin
                            hit                = 1'b1;
                            res.status         = STAT_OK;
                            res.found_position = i[6:0];
                        end
                    end
                end
            endcase
            res.list_length = fill[7:0];
            res.is_empty    = (fill == 0);
            res.is_full     = (fill == CAPACITY);
            return res;
        end
    endfunction

    task automatic compare_field(input string label, input logic [31:0] want,
                                 input logic [31:0] got);
        if (want !== got)
        begin
            fails++;
            $display("%0t: %s mismatch, expected %0h, got %0h", $time, label, want, got);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill = 0;
            awaited_results.delete();
        end
        else
        begin
            if (in_valid && !in_stall)
                awaited_results.push_back(apply_action(action, position, value));
            if (out_valid && !out_stall)
            begin
                if (awaited_results.size() == 0)
                begin
                    fails++;
                    $display("%0t: result transfer with nothing awaited, status %0h",
                             $time, status);
                end
                else
                begin
                    oldest = awaited_results.pop_front();
                    compare_field("status", 32'(oldest.status), 32'(status));
                    compare_field("found_position", 32'(oldest.found_position),
                                  32'(found_position));
                    compare_field("read_value", oldest.read_value, read_value);
                    compare_field("list_length", 32'(oldest.list_length),
                                  32'(list_length));
                    compare_field("is_empty", 32'(oldest.is_empty), 32'(is_empty));
                    compare_field("is_full", 32'(oldest.is_full), 32'(is_full));
                end
            end
        end
        mismatch_count <= fails;
        outstanding    <= awaited_results.size();
    end

endmodule

`default_nettype wire

// File: sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench: stimulus and verdict for the ordered list engine
// Directed edge cases first, then random insert/delete/read/search traffic
// that repeatedly fills the list to capacity and drains it; checking is done
// by list_checker sitting beside the engine.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import oal_pkg::*;

    localparam int CLK_PERIOD   = 12;
    localparam int RESET_CYCLES = 7;
    localparam int RANDOM_ITEMS = 1850;
    // hard limit set well above the slowest legal run; keep a wide margin
    localparam int LIMIT_CYCLES = 600000;
    // window with no idling on either side
    localparam int QUIET_FROM   = 4000;
    localparam int QUIET_TO     = 9000;
    // settle time after the last awaited result has been taken
    localparam int DRAIN_CYCLES = 24;

    logic               clk;
    logic               rst_n;
    logic               in_valid;
    logic               in_stall;
    logic [1:0]         action;
    logic [7:0]         position;
    logic signed [31:0] value;
    logic               out_valid;
    logic               out_stall;
    logic [1:0]         status;
    logic [6:0]         found_position;
    logic signed [31:0] read_value;
    logic [7:0]         list_length;
    logic               is_empty;
    logic               is_full;

    int mismatch_count;
    int outstanding;
    int cycle_count = 0;
    // length as the stimulus sees it, used to aim positions and switch grow/shrink phases
    int list_fill   = 0;

    ordered_array_list_engine dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_position (found_position),
        .read_value     (read_value),
        .list_length    (list_length),
        .is_empty       (is_empty),
        .is_full        (is_full)
    );

    list_checker list_check (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .action         (action),
        .position       (position),
        .value          (value),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .found_position (found_position),
        .read_value     (read_value),
        .list_length    (list_length),
        .is_empty       (is_empty),
        .is_full        (is_full),
        .mismatch_count (mismatch_count),
        .outstanding    (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // hard stop in case a transfer never completes
    initial
    begin
        #(CLK_PERIOD * LIMIT_CYCLES);
        $display("DONE: errors detected");
        $finish;
    end

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    // ~6% idle cycles, none inside the quiet window
    function automatic bit take_break();
        if (cycle_count >= QUIET_FROM && cycle_count < QUIET_TO)
            return 1'b0;
        return ($urandom_range(0, 99) < 6);
    endfunction

    // receiver: random stall, independent of out_valid
    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            out_stall <= take_break();
        end
    end

    // Mostly a small pool so searches hit and duplicates occur;
    // some extremes and some full-width random words to toggle every bit.
    function automatic logic [31:0] pick_value();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return $urandom_range(0, 15) - 8;
        if (r < 65)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h7FFF_FFFF;
                1:       return 32'h8000_0000;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        return $urandom();
    endfunction

    // Mostly in range, with the ends and the first bad position favored,
    // plus some arbitrary 8-bit positions.
    function automatic int pick_position(input logic [1:0] act);
        int r;
        r = $urandom_range(0, 99);
        if (r < 6)
            return $urandom_range(0, 255);
        if (act == ACT_INSERT)
        begin
            if (r < 12)
                return list_fill + 1;
            if (r < 24)
                return list_fill;
            if (r < 30)
                return 0;
            return $urandom_range(0, list_fill);
        end
        if (r < 12 || list_fill == 0)
            return list_fill;
        if (r < 20)
            return list_fill - 1;
        return $urandom_range(0, list_fill - 1);
    endfunction

    // one transfer on the input channel; payload holds while stalled
    task automatic send_item(input logic [1:0] act, input int pos, input logic [31:0] val);
        while (take_break())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        action   <= act;
        position <= pos[7:0];
        value    <= val;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // follow the length so later positions can be aimed
        if (act == ACT_INSERT && list_fill < CAPACITY && pos[7:0] <= list_fill)
            list_fill++;
        else if (act == ACT_DELETE && pos[7:0] < list_fill)
            list_fill--;
    endtask

    initial
    begin
        logic [1:0] act;
        int         r;
        bit         growing;

        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        action   <= ACT_INSERT;
        position <= '0;
        value    <= '0;
        growing  = 1'b1;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty list: every position is out of range, search misses
        send_item(ACT_READ, 0, 32'h0);
        send_item(ACT_DELETE, 0, 32'h0);
        send_item(ACT_SEARCH, 0, 32'h0);
        send_item(ACT_INSERT, 1, 32'h1);
        // build [min, 0, max, -1, 0] by head, append and middle inserts
        send_item(ACT_INSERT, 0, 32'h7FFF_FFFF);
        send_item(ACT_INSERT, 0, 32'h8000_0000);
        send_item(ACT_INSERT, 2, 32'hFFFF_FFFF);
        send_item(ACT_INSERT, 1, 32'h0);
        send_item(ACT_INSERT, 4, 32'h0);
        send_item(ACT_INSERT, 255, 32'h5);
        // reads at both ends, just past the end and at the top position
        send_item(ACT_READ, 0, 32'h0);
        send_item(ACT_READ, 4, 32'h0);
        send_item(ACT_READ, 5, 32'h0);
        send_item(ACT_READ, 255, 32'hFFFF_FFFF);
        // duplicate value: first position must win
        send_item(ACT_SEARCH, 200, 32'h0);
        send_item(ACT_SEARCH, 0, 32'hFFFF_FFFF);
        send_item(ACT_SEARCH, 0, 32'h1234_5678);
        // deletes: past the end, head, tail
        send_item(ACT_DELETE, 5, 32'h0);
        send_item(ACT_DELETE, 0, 32'h0);
        send_item(ACT_DELETE, 3, 32'h0);
        send_item(ACT_SEARCH, 0, 32'h7FFF_FFFF);
        send_item(ACT_READ, 2, 32'h0);

        // Random traffic in grow/shrink phases: grow until full and hammer
        // inserts there for a while, then shrink until empty, and repeat.
        repeat (RANDOM_ITEMS)
        begin
            r = $urandom_range(0, 99);
            if (growing)
                act = (r < 55) ? ACT_INSERT : (r < 65) ? ACT_DELETE :
                      (r < 85) ? ACT_READ : ACT_SEARCH;
            else
                act = (r < 10) ? ACT_INSERT : (r < 65) ? ACT_DELETE :
                      (r < 85) ? ACT_READ : ACT_SEARCH;
            send_item(act, pick_position(act), pick_value());
            if (growing && list_fill == CAPACITY && $urandom_range(0, 9) == 0)
                growing = 1'b0;
            else if (!growing && list_fill == 0 && $urandom_range(0, 4) == 0)
                growing = 1'b1;
        end
        in_valid <= 1'b0;

        // let the last push reach the counter, then drain
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (mismatch_count == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
